@@ design/bfmr_pkg.sv @@
// Shared types, codes and pointer helpers for the byte ring FIFO with mark/rewind.
package bfmr_pkg;

    // Byte store geometry
    localparam int SLOTS   = 256;
    localparam int PTR_W   = $clog2(SLOTS);
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 8;
    localparam int LVL_W   = 8;

    // Largest usable capacity: one slot always stays spare
    localparam logic [LVL_W-1:0] CAP_MAX = LVL_W'(SLOTS - 1);

    // Action codes
    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_READ   = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_SKIP   = 3'd3,
        ACT_MARK   = 3'd4,
        ACT_REWIND = 3'd5,
        ACT_UNGET  = 3'd6,
        ACT_CLEAR  = 3'd7
    } action_t;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Byte store access for one item
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } mem_req_t;

    // Result fields known at acceptance; data comes from the store's read register the cycle after
    typedef struct packed {
        logic              rd_sel;
        logic [1:0]        status;
        logic [CNT_W-1:0]  moved;
        logic [LVL_W-1:0]  level;
    } res_t;

    // Pointer advance with wrap at slots; ptr < slots and n < slots
    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0] ptr,
        input logic [PTR_W-1:0] n,
        input logic [PTR_W:0]   slots
    );
        logic [PTR_W:0] sum;
        begin
            sum = {1'b0, ptr} + {1'b0, n};
            if (sum >= slots)
            begin
                sum = sum - slots;
            end
            return sum[PTR_W-1:0];
        end
    endfunction

endpackage

@@ design/byte_ring_fifo_mark_rewind.sv @@
// Top level: byte ring FIFO with mark/rewind, one action per clock.
//
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+---------------------------
//  item in  | action, data_in, count                | start high, busy low
//  result   | data_out, status, moved, level        | done high for one cycle
//  config   | cfg_data                              | cfg_we high, no wait
//
// One item is accepted every clock; busy stays low.
// The result of an item appears in the cycle after it is accepted, set by the
// registered read port of the byte store.
// Reset clears the pointers, level and capacity (to 255); the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module byte_ring_fifo_mark_rewind
    import bfmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LVL_W-1:0]  cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        action,
    input  logic [DATA_W-1:0] data_in,
    input  logic [CNT_W-1:0]  count,
    output logic              done,
    output logic [DATA_W-1:0] data_out,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  moved,
    output logic [LVL_W-1:0]  level
);

    logic              item_en;
    mem_req_t          req;
    res_t              res;
    res_t              res_reg;
    logic              done_reg;
    logic [DATA_W-1:0] rd_data;

    // Single-pass datapath never holds off an item
    assign busy    = 1'b0;
    assign item_en = start && !busy;

    bfmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item_en  (item_en),
        .action   (action),
        .data_in  (data_in),
        .count    (count),
        .req      (req),
        .res      (res)
    );

    bfmr_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            res_reg <= res;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_en;
        end
    end

    // Byte from the store only for a read or peek that went through
    assign done     = done_reg;
    assign data_out = res_reg.rd_sel ? rd_data : '0;
    assign status   = res_reg.status;
    assign moved    = res_reg.moved;
    assign level    = res_reg.level;

    // Every accepted item yields exactly one result the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_en |=> done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !item_en |=> !done)
        else $error("result without accepted item");

    // A byte is returned only with done status
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && res_reg.rd_sel |-> status == ST_DONE)
        else $error("byte returned on refused action");

endmodule

@@ design/bfmr_store.sv @@
// Byte store: one write port and one registered read port.
module bfmr_store
    import bfmr_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [SLOTS];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bfmr_ctrl.sv @@
// Pointer, level and capacity registers with the per-item action decode.
module bfmr_ctrl
    import bfmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LVL_W-1:0]  cfg_data,
    input  logic              item_en,
    input  logic [2:0]        action,
    input  logic [DATA_W-1:0] data_in,
    input  logic [CNT_W-1:0]  count,
    output mem_req_t          req,
    output res_t              res
);

    logic [LVL_W-1:0] cap_reg;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] mp_reg, mp_next;
    logic [LVL_W-1:0] level_reg, level_next;

    logic [LVL_W-1:0] cap_eff;
    logic [PTR_W:0]   slots;
    logic             full;
    logic             empty;
    logic [LVL_W-1:0] skip_n;
    logic [PTR_W:0]   rew_gap;
    logic [PTR_W:0]   rew_sum;
    logic [PTR_W-1:0] rp_dec;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] peek_addr;
    logic [PTR_W-1:0] skip_rp;

    // Effective capacity and ring size
    always_comb
    begin
        cap_eff = (cap_reg == '0) ? LVL_W'(1) : cap_reg;
        if (cap_eff > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
        slots = {1'b0, cap_eff} + (PTR_W+1)'(1);
    end

    // Shared pointer arithmetic
    always_comb
    begin
        full      = (level_reg >= cap_eff);
        empty     = (level_reg == '0);
        skip_n    = (count < level_reg) ? count : level_reg;
        rp_inc    = wrap_add(rp_reg, PTR_W'(1), slots);
        wp_inc    = wrap_add(wp_reg, PTR_W'(1), slots);
        peek_addr = wrap_add(rp_reg, count, slots);
        skip_rp   = wrap_add(rp_reg, skip_n, slots);
        rp_dec    = (rp_reg == '0) ? PTR_W'(slots - (PTR_W+1)'(1)) : rp_reg - PTR_W'(1);
        rew_gap   = (rp_reg >= mp_reg) ? {1'b0, rp_reg} - {1'b0, mp_reg}
                                       : slots - {1'b0, mp_reg} + {1'b0, rp_reg};
        rew_sum   = {1'b0, level_reg} + rew_gap;
    end

    // Action decode
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        mp_next    = mp_reg;
        level_next = level_reg;
        req        = '0;
        req.wr_data = data_in;
        res.rd_sel = 1'b0;
        res.status = ST_DONE;
        res.moved  = '0;

        unique case (action_t'(action))
            ACT_WRITE:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = wp_reg;
                    wp_next     = wp_inc;
                    level_next  = level_reg + LVL_W'(1);
                    res.moved   = CNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = rp_reg;
                    res.rd_sel  = 1'b1;
                    rp_next     = rp_inc;
                    level_next  = level_reg - LVL_W'(1);
                    res.moved   = CNT_W'(1);
                end
            end
            ACT_PEEK:
            begin
                if (count >= level_reg)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = peek_addr;
                    res.rd_sel  = 1'b1;
                end
            end
            ACT_SKIP:
            begin
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    rp_next    = skip_rp;
                    level_next = level_reg - skip_n;
                    res.moved  = skip_n;
                end
            end
            ACT_MARK:
            begin
                mp_next = rp_reg;
            end
            ACT_REWIND:
            begin
                // refused when the restored bytes would overfill the ring
                if (mp_reg != rp_reg)
                begin
                    if (rew_sum > {1'b0, cap_eff})
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        rp_next    = mp_reg;
                        level_next = rew_sum[LVL_W-1:0];
                        res.moved  = rew_gap[CNT_W-1:0];
                    end
                end
            end
            ACT_UNGET:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    rp_next     = rp_dec;
                    req.wr_en   = 1'b1;
                    req.wr_addr = rp_dec;
                    level_next  = level_reg + LVL_W'(1);
                    res.moved   = CNT_W'(1);
                end
            end
            ACT_CLEAR:
            begin
                rp_next    = '0;
                wp_next    = '0;
                mp_next    = '0;
                level_next = '0;
            end
        endcase

        res.level = level_next;

        // no store access unless an item is taken
        if (!item_en)
        begin
            req.wr_en = 1'b0;
            req.rd_en = 1'b0;
        end
    end

    // State registers; a capacity write empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_MAX;
            rp_reg    <= '0;
            wp_reg    <= '0;
            mp_reg    <= '0;
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cfg_data;
            rp_reg    <= '0;
            wp_reg    <= '0;
            mp_reg    <= '0;
            level_reg <= '0;
        end
        else if (item_en)
        begin
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            mp_reg    <= mp_next;
            level_reg <= level_next;
        end
    end

    // Level never exceeds the effective capacity
    a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= cap_eff)
        else $error("fill level above capacity");

    // Write pointer always sits level bytes past the read pointer
    a_wp_track: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg == wrap_add(rp_reg, level_reg, slots))
        else $error("write pointer out of step with read pointer and level");

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rp_reg} < slots && {1'b0, mp_reg} < slots)
        else $error("pointer outside ring");

    // Store is never read and written by the same item
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("read and write issued together");

endmodule
